FILE: rtl/qlcd_pkg.sv
// Package for the QSPI LCD command and pixel serializer.
// Holds the opcode codes, the work descriptor and the result types. No dependencies.
package qlcd_pkg;

    typedef enum logic [2:0] {
        OP_WRITE_CMD   = 3'd0,
        OP_PARAM_BYTE  = 3'd1,
        OP_READ_CMD    = 3'd2,
        OP_READ_BIT    = 3'd3,
        OP_PIXEL_START = 3'd4,
        OP_PIXEL       = 3'd5,
        OP_SELECT      = 3'd6,
        OP_DESELECT    = 3'd7
    } t_opcode;

    localparam logic [7:0]  WRITE_LEAD = 8'h02;
    localparam logic [7:0]  READ_LEAD  = 8'h03;
    // Pixel start: 0x12 on one line, then 00,2C,00 as quad nibbles.
    localparam logic [31:0] PIXEL_START_PATTERN = 32'h12002C00;

    // One unit of work for the back end. The pattern shifts out from its top:
    // one bit per pulse while single-line pulses remain, then one nibble per pulse.
    typedef struct packed {
        logic [31:0] pattern;
        logic [4:0]  remaining;    // results still to come, minus one
        logic [5:0]  singles;      // single-line pulses still to come
        logic        select_lead;  // next result is a chip-select change
        logic        chip_select;
        logic        d0_driven;
        logic [7:0]  read_byte;
        logic        read_valid;
    } t_work;

    typedef struct packed {
        logic [3:0] data_lines;
        logic       clock_pulse;
        logic       chip_select;
        logic       d0_driven;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       last;
    } t_result;

endpackage

FILE: rtl/qlcd_front.sv
// Front end: accepts input items, updates select and read state, and builds work items.
// Depends on qlcd_pkg.
module qlcd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_opcode,
    input  logic [15:0]          i_data_word,
    input  logic                 i_line_in,
    output qlcd_pkg::t_work      o_work
);
    import qlcd_pkg::*;

    logic       r_selected, n_selected;
    logic [7:0] r_read_shift, n_read_shift;
    logic [2:0] r_read_count, n_read_count;
    logic       r_released, n_released;

    logic [7:0] shifted;
    logic [2:0] count_inc;

    assign shifted   = {r_read_shift[6:0], i_line_in};
    assign count_inc = r_read_count + 3'd1;

    always_comb begin
        n_selected   = r_selected;
        n_read_shift = r_read_shift;
        n_read_count = r_read_count;
        n_released   = r_released;
        o_work       = '0;
        o_work.d0_driven = 1'b1;

        case (t_opcode'(i_opcode))
            OP_WRITE_CMD, OP_READ_CMD: begin
                n_read_shift = '0;
                n_read_count = '0;
                n_released   = (t_opcode'(i_opcode) == OP_READ_CMD);
                o_work.pattern   = {(t_opcode'(i_opcode) == OP_READ_CMD) ? READ_LEAD
                                                                          : WRITE_LEAD,
                                    8'h00, i_data_word[7:0], 8'h00};
                o_work.remaining = 5'd31;
                o_work.singles   = 6'd32;
            end
            OP_PARAM_BYTE: begin
                n_read_shift = '0;
                n_read_count = '0;
                n_released   = 1'b0;
                o_work.pattern   = {i_data_word[7:0], 24'h0};
                o_work.remaining = 5'd7;
                o_work.singles   = 6'd8;
            end
            OP_READ_BIT: begin
                n_released   = 1'b1;
                n_read_count = count_inc;
                n_read_shift = (count_inc == 3'd0) ? 8'h00 : shifted;
                o_work.remaining  = 5'd0;
                o_work.singles    = 6'd1;
                o_work.d0_driven  = 1'b0;
                o_work.read_valid = (count_inc == 3'd0);
                o_work.read_byte  = (count_inc == 3'd0) ? shifted : 8'h00;
            end
            OP_PIXEL_START: begin
                n_read_shift = '0;
                n_read_count = '0;
                n_released   = 1'b0;
                n_selected   = 1'b1;
                o_work.pattern     = PIXEL_START_PATTERN;
                o_work.select_lead = !r_selected;
                o_work.remaining   = r_selected ? 5'd13 : 5'd14;
                o_work.singles     = 6'd8;
            end
            OP_PIXEL: begin
                n_read_shift = '0;
                n_read_count = '0;
                n_released   = 1'b0;
                o_work.pattern   = {i_data_word, 16'h0};
                o_work.remaining = 5'd3;
                o_work.singles   = 6'd0;
            end
            OP_SELECT, OP_DESELECT: begin
                n_selected = (t_opcode'(i_opcode) == OP_SELECT);
                o_work.select_lead = 1'b1;
                o_work.remaining   = 5'd0;
                o_work.d0_driven   = !r_released;
            end
            default: begin
                o_work.remaining = 5'd0;
            end
        endcase
        o_work.chip_select = n_selected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected   <= 1'b0;
            r_read_shift <= '0;
            r_read_count <= '0;
            r_released   <= 1'b0;
        end else if (i_accept) begin
            r_selected   <= n_selected;
            r_read_shift <= n_read_shift;
            r_read_count <= n_read_count;
            r_released   <= n_released;
        end
    end

endmodule

FILE: rtl/qlcd_queue.sv
// Two-entry queue of work items between the front and back ends.
// Depends on qlcd_pkg.
module qlcd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qlcd_pkg::t_work      i_work,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output qlcd_pkg::t_work      o_work
);
    import qlcd_pkg::*;

    t_work      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_work  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

FILE: rtl/qlcd_back.sv
// Back end: steps items one result per cycle into its output reg unless stalled.
// Depends on qlcd_pkg.
module qlcd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  qlcd_pkg::t_work      i_q_work,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    output qlcd_pkg::t_result    o_result,
    input  logic                 i_out_take
);
    import qlcd_pkg::*;

    t_work   r_cur, n_cur;
    logic    r_active;
    t_result r_out, emit;
    logic    r_out_valid;
    t_work   w;
    logic    have, can_emit, fire;

    assign w        = r_active ? r_cur : i_q_work;
    assign have     = r_active || i_q_valid;
    assign can_emit = !r_out_valid || i_out_take;
    assign fire     = have && can_emit;
    assign o_q_pop  = fire && !r_active;

    always_comb begin
        emit = '0;
        emit.chip_select = w.chip_select;
        emit.d0_driven   = w.d0_driven;
        emit.read_byte   = w.read_byte;
        emit.read_valid  = w.read_valid;
        emit.last        = (w.remaining == 5'd0);
        n_cur            = w;
        n_cur.remaining  = w.remaining - 5'd1;
        if (w.select_lead) begin
            n_cur.select_lead = 1'b0;
        end else if (w.singles != 6'd0) begin
            emit.clock_pulse = 1'b1;
            emit.data_lines  = {3'b000, w.pattern[31]};
            n_cur.pattern    = {w.pattern[30:0], 1'b0};
            n_cur.singles    = w.singles - 6'd1;
        end else begin
            emit.clock_pulse = 1'b1;
            emit.data_lines  = w.pattern[31:28];
            n_cur.pattern    = {w.pattern[27:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= emit;
            r_cur <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_active    <= !emit.last;
                r_out_valid <= 1'b1;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

FILE: rtl/qspi_lcd_command_pixel_serializer_unit.sv
// Top level of the QSPI LCD command and pixel serializer.
// Depends on qlcd_pkg, qlcd_front, qlcd_queue and qlcd_back.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------------
//  input     i_push / o_full      i_opcode, i_data_word, i_line_in
//  result    o_empty / i_pop      o_data_lines, o_clock_pulse, o_chip_select,
//                                 o_d0_driven, o_read_byte, o_read_valid, o_last
//
// The back end hands out an item's results one at a time through its output
// register: 32 results for a command header, 8 for a parameter byte, 14 or 15
// for a pixel start, 4 for a pixel and 1 for a read bit or a select change.
// The rate is set by the back end's single result path.
// Reset is synchronous and active low; it deselects the panel, drives D0 and
// clears any partial read byte. A stalled result holds in the output register
// while the back end waits; the two-entry queue lets the front end keep
// accepting items until it fills.
module qspi_lcd_command_pixel_serializer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [2:0]  i_opcode,
    input  logic [15:0] i_data_word,
    input  logic        i_line_in,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [3:0]  o_data_lines,
    output logic        o_clock_pulse,
    output logic        o_chip_select,
    output logic        o_d0_driven,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_last
);
    import qlcd_pkg::*;

    t_work   front_work;
    t_work   q_work;
    t_result result;
    logic    accept;
    logic    q_valid;
    logic    q_pop;
    logic    out_valid;

    // The front end updates its select and read state at the same edge that
    // the item enters the queue, so later items see the new state at once.
    assign accept = i_push && !o_full;

    qlcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_data_word (i_data_word),
        .i_line_in   (i_line_in),
        .o_work      (front_work)
    );

    qlcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_work  (front_work),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // The back end starts on the head of the queue directly, so a one-result
    // item leaves the queue in the same cycle that its result is registered.
    qlcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_work    (q_work),
        .o_q_pop     (q_pop),
        .o_out_valid (out_valid),
        .o_result    (result),
        .i_out_take  (i_pop)
    );

    assign o_empty       = !out_valid;
    assign o_data_lines  = result.data_lines;
    assign o_clock_pulse = result.clock_pulse;
    assign o_chip_select = result.chip_select;
    assign o_d0_driven   = result.d0_driven;
    assign o_read_byte   = result.read_byte;
    assign o_read_valid  = result.read_valid;
    assign o_last        = result.last;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for qspi_lcd_command_pixel_serializer_unit.
// Depends on qlcd_pkg for the opcodes, the lead bytes and the result struct.
`timescale 1ns / 100ps

module tb_top;
    import qlcd_pkg::*;

    // Directed rows come first; the random sequences follow until about this
    // many more items have been accepted.
    localparam int SCRIPT_ROWS  = 25;
    localparam int RANDOM_ITEMS = 130;
    // The receiver holds off once this many results have been checked, for the
    // stretch that HOLD_CYCLES sets, so the queue fills and raises o_full.
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    // Cycles to keep watching the outputs after the last expected result.
    localparam int DRAIN_CYCLES = 64;

    // One directed row. When typed is set, want is the single result the item
    // must give, written out by hand instead of taken from the predictor.
    typedef struct packed {
        t_opcode     op;
        logic [15:0] word;
        logic        line;
        logic        typed;
        t_result     want;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [2:0]  i_opcode;
    logic [15:0] i_data_word;
    logic        i_line_in;
    logic        o_empty;
    logic        i_pop;
    logic [3:0]  o_data_lines;
    logic        o_clock_pulse;
    logic        o_chip_select;
    logic        o_d0_driven;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_last;

    // Predictor state: a private copy of what the block remembers between items.
    logic        pan_selected;
    logic [7:0]  rd_shift;
    logic [2:0]  rd_count;
    logic        d0_released;

    // Expected results in the order the block must hand them out.
    t_result     pending_pulses[$];

    t_step_row   script[SCRIPT_ROWS];
    int          items_sent;
    int          pulses_checked;
    int          mismatches;
    int          op_seen[8];
    bit          calm;       // set during the stretch where neither side idles
    bit          hold_done;

    qspi_lcd_command_pixel_serializer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_opcode      (i_opcode),
        .i_data_word   (i_data_word),
        .i_line_in     (i_line_in),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_data_lines  (o_data_lines),
        .o_clock_pulse (o_clock_pulse),
        .o_chip_select (o_chip_select),
        .o_d0_driven   (o_d0_driven),
        .o_read_byte   (o_read_byte),
        .o_read_valid  (o_read_valid),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one result. Chip select and the D0 direction are taken from the
    // predictor state as it stands when the result is produced.
    function automatic void emit_pulse(logic [3:0] lines, logic clk_pulse,
                                       logic [7:0] rbyte, logic rvalid);
        t_result r;
        r.data_lines  = lines;
        r.clock_pulse = clk_pulse;
        r.chip_select = pan_selected;
        r.d0_driven   = ~d0_released;
        r.read_byte   = rbyte;
        r.read_valid  = rvalid;
        r.last        = 1'b0;
        pending_pulses.push_back(r);
    endfunction

    // Single-line byte: eight pulses on D0, MSB first, D1..D3 held low.
    function automatic void emit_serial_byte(logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            emit_pulse({3'b000, b[i]}, 1'b1, 8'h00, 1'b0);
        end
    endfunction

    // Quad byte: two pulses, high nibble first.
    function automatic void emit_quad_byte(logic [7:0] b);
        emit_pulse(b[7:4], 1'b1, 8'h00, 1'b0);
        emit_pulse(b[3:0], 1'b1, 8'h00, 1'b0);
    endfunction

    // Four-byte command header: lead byte, 00, command, 00, all on D0.
    function automatic void emit_header(logic [7:0] lead, logic [7:0] cmd);
        emit_serial_byte(lead);
        emit_serial_byte(8'h00);
        emit_serial_byte(cmd);
        emit_serial_byte(8'h00);
    endfunction

    // Works out every result one accepted item causes, appends them to
    // pending_pulses with the final one marked, and returns how many.
    function automatic int serialize_item(t_opcode op, logic [15:0] word, logic line);
        int      first;
        t_result tail;
        first = pending_pulses.size();

        // Every item that drives pins takes D0 back and drops a partial read.
        if (op inside {OP_WRITE_CMD, OP_PARAM_BYTE, OP_READ_CMD,
                       OP_PIXEL_START, OP_PIXEL}) begin
            d0_released = 1'b0;
            rd_shift    = 8'h00;
            rd_count    = 3'd0;
        end

        case (op)
            OP_WRITE_CMD: begin
                emit_header(WRITE_LEAD, word[7:0]);
            end
            OP_PARAM_BYTE: begin
                emit_serial_byte(word[7:0]);
            end
            OP_READ_CMD: begin
                // The header still goes out with D0 driven; it is released after.
                emit_header(READ_LEAD, word[7:0]);
                d0_released = 1'b1;
            end
            OP_READ_BIT: begin
                // A read bit releases D0 even without a read command before it.
                d0_released = 1'b1;
                rd_shift    = {rd_shift[6:0], line};
                rd_count    = rd_count + 3'd1;
                if (rd_count == 3'd0) begin
                    emit_pulse(4'h0, 1'b1, rd_shift, 1'b1);
                    rd_shift = 8'h00;
                end else begin
                    emit_pulse(4'h0, 1'b1, 8'h00, 1'b0);
                end
            end
            OP_PIXEL_START: begin
                // Selects the panel first; the select result only appears
                // when the panel was deselected.
                if (!pan_selected) begin
                    pan_selected = 1'b1;
                    emit_pulse(4'h0, 1'b0, 8'h00, 1'b0);
                end
                emit_serial_byte(PIXEL_START_PATTERN[31:24]);
                emit_quad_byte(PIXEL_START_PATTERN[23:16]);
                emit_quad_byte(PIXEL_START_PATTERN[15:8]);
                emit_quad_byte(PIXEL_START_PATTERN[7:0]);
            end
            OP_PIXEL: begin
                emit_quad_byte(word[15:8]);
                emit_quad_byte(word[7:0]);
            end
            OP_SELECT: begin
                pan_selected = 1'b1;
                emit_pulse(4'h0, 1'b0, 8'h00, 1'b0);
            end
            default: begin
                pan_selected = 1'b0;
                emit_pulse(4'h0, 1'b0, 8'h00, 1'b0);
            end
        endcase

        tail = pending_pulses.pop_back();
        tail.last = 1'b1;
        pending_pulses.push_back(tail);
        return pending_pulses.size() - first;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one item from the falling edge on and returns at the falling edge
    // after it was taken. i_push is left high so that back-to-back items keep
    // it high without a glitch; the next call or the caller lowers it.
    task automatic send_item(t_opcode op, logic [15:0] word, logic line,
                             logic typed, t_result want);
        int n;
        calm = (items_sent >= 80) && (items_sent < 130);
        while (!calm && $urandom_range(99) < 6) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_opcode    <= op;
        i_data_word <= word;
        i_line_in   <= line;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);

        // Accepted at this edge.
        n = serialize_item(op, word, line);
        if (typed) begin
            // Hand-written rows replace the predicted result of a one-result item.
            repeat (n) void'(pending_pulses.pop_back());
            pending_pulses.push_back(want);
        end
        op_seen[op]++;
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(t_opcode op);
        send_item(op, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    function automatic int field_bad(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_pulse();
        t_result want;
        if (pending_pulses.size() == 0) begin
            $display("%0t: result with nothing expected, lines 0x%0h last %0b",
                     $time, o_data_lines, o_last);
            mismatches++;
        end else begin
            want = pending_pulses.pop_front();
            mismatches += field_bad("data_lines",  want.data_lines,  o_data_lines);
            mismatches += field_bad("clock_pulse", want.clock_pulse, o_clock_pulse);
            mismatches += field_bad("chip_select", want.chip_select, o_chip_select);
            mismatches += field_bad("d0_driven",   want.d0_driven,   o_d0_driven);
            mismatches += field_bad("read_byte",   want.read_byte,   o_read_byte);
            mismatches += field_bad("read_valid",  want.read_valid,  o_read_valid);
            mismatches += field_bad("last",        want.last,        o_last);
        end
        pulses_checked++;
    endtask

    // The receiver pops at the falling edge and checks at the rising edge.
    // Once, early in the random part, it holds off for a long stretch so the
    // block backs up and the sender sees o_full.
    initial begin
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && pulses_checked >= HOLD_AFTER) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_pop <= calm || ($urandom_range(99) >= 6);
            @(posedge i_clk);
            if (i_pop && !o_empty) check_pulse();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_opcode    = OP_WRITE_CMD;
        i_data_word = 16'h0000;
        i_line_in   = 1'b0;
        items_sent  = 0;
        pulses_checked = 0;
        mismatches  = 0;
        calm        = 1'b0;
        hold_done   = 1'b0;
        foreach (op_seen[i]) op_seen[i] = 0;
        pan_selected = 1'b0;
        rd_shift     = 8'h00;
        rd_count     = 3'd0;
        d0_released  = 1'b0;

        // Typed results are {lines, clock, select, d0 driven, byte, valid, last}.
        // Select straight out of reset: panel selected, D0 still driven.
        script[0]  = '{OP_SELECT,      16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1}};
        // Header with every data bit set; only the low byte reaches the pins.
        script[1]  = '{OP_WRITE_CMD,   16'hFFFF, 1'b1, 1'b0, '0};
        script[2]  = '{OP_PARAM_BYTE,  16'hFF00, 1'b0, 1'b0, '0};
        script[3]  = '{OP_PARAM_BYTE,  16'h00FF, 1'b1, 1'b0, '0};
        script[4]  = '{OP_READ_CMD,    16'h00A5, 1'b0, 1'b0, '0};
        // Eight read bits 1,0,1,1,0,0,1,1 assemble 0xB3 on the eighth.
        script[5]  = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[6]  = '{OP_READ_BIT,    16'hFFFF, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[7]  = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[8]  = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[9]  = '{OP_READ_BIT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[10] = '{OP_READ_BIT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[11] = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[12] = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'hB3, 1'b1, 1'b1}};
        // Start of a second byte, abandoned by the write command that follows.
        script[13] = '{OP_READ_BIT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}};
        script[14] = '{OP_WRITE_CMD,   16'h0000, 1'b0, 1'b0, '0};
        // Deselect twice: the second gives a result although nothing changes.
        script[15] = '{OP_DESELECT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1}};
        script[16] = '{OP_DESELECT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1}};
        // Read bit with no read command, while deselected: D0 is released anyway.
        script[17] = '{OP_READ_BIT,    16'h0000, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1}};
        // Pixel start from deselected carries a leading select result.
        script[18] = '{OP_PIXEL_START, 16'h0000, 1'b0, 1'b0, '0};
        script[19] = '{OP_PIXEL,       16'hFFFF, 1'b0, 1'b0, '0};
        script[20] = '{OP_PIXEL,       16'h0000, 1'b0, 1'b0, '0};
        // Pixel start while already selected: pulses only.
        script[21] = '{OP_PIXEL_START, 16'hFFFF, 1'b1, 1'b0, '0};
        script[22] = '{OP_PIXEL,       16'h1234, 1'b0, 1'b0, '0};
        script[23] = '{OP_SELECT,      16'hFFFF, 1'b1, 1'b1,
                       t_result'{4'h0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1}};
        script[24] = '{OP_DESELECT,    16'h0000, 1'b0, 1'b1,
                       t_result'{4'h0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1}};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            send_item(script[i].op, script[i].word, script[i].line,
                      script[i].typed, script[i].want);
        end

        // Random part: mostly well-formed transactions with random content,
        // plus stray items that arrive without their lead-in and pure noise.
        while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0, 1: begin
                    send_random(OP_WRITE_CMD);
                    repeat ($urandom_range(4)) send_random(OP_PARAM_BYTE);
                end
                2, 3: begin
                    // Up to 20 bits, so reads cross byte boundaries and often
                    // stop partway through a byte.
                    send_random(OP_READ_CMD);
                    repeat ($urandom_range(1, 20)) send_random(OP_READ_BIT);
                end
                4, 5, 6: begin
                    send_random(OP_PIXEL_START);
                    repeat ($urandom_range(1, 8)) send_random(OP_PIXEL);
                end
                7: begin
                    send_random($urandom_range(1) ? OP_SELECT : OP_DESELECT);
                end
                8: begin
                    case ($urandom_range(2))
                        0: send_random(OP_PIXEL);
                        1: send_random(OP_PARAM_BYTE);
                        default: send_random(OP_READ_BIT);
                    endcase
                end
                default: begin
                    send_random(t_opcode'($urandom_range(7)));
                end
            endcase
        end
        i_push <= 1'b0;

        // Let the block drain, then keep watching for anything extra.
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pulses.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_pulses.size());
            mismatches++;
        end

        $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, pulses_checked, mismatches);
        $display("tb_top: per opcode wr %0d par %0d rd %0d bit %0d pxs %0d px %0d sel %0d des %0d",
                 op_seen[OP_WRITE_CMD], op_seen[OP_PARAM_BYTE], op_seen[OP_READ_CMD],
                 op_seen[OP_READ_BIT], op_seen[OP_PIXEL_START], op_seen[OP_PIXEL],
                 op_seen[OP_SELECT], op_seen[OP_DESELECT]);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results still expected", $time, pending_pulses.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
